/* rtl/fpa_pkg.sv */
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 8;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int NUM_W     = WORD_W + FRAC_W;
    localparam int DIV_STEPS = 4;
    localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_NUM_W = DIV_STAGES * DIV_STEPS;
    localparam int MUL_MAG_W = PROD_W + 1 - FRAC_W;
    localparam int DIV_MAG_W = DIV_NUM_W + 1;
    localparam int MAG_W     = (MUL_MAG_W > DIV_MAG_W) ? MUL_MAG_W : DIV_MAG_W;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
        OP_EQ, OP_NE, OP_INC, OP_DEC, OP_MIN, OP_MAX, OP_FROM_INT, OP_TO_INT
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    typedef struct packed {
        logic                     valid;
        op_t                      mode;
        logic                     neg;
        logic                     div_zero;
        logic                     cmp;
        logic signed [WORD_W-1:0] simple_r;
    } side_t;

    typedef struct packed {
        side_t               side;
        logic [PROD_W-1:0]   prod;
    } carry_t;

    typedef struct packed {
        logic [WORD_W-1:0]    rem;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_NUM_W-1:0] quo;
        logic [WORD_W-1:0]    divisor;
    } div_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result_word;
        logic                     compare_true;
        status_t                  status;
    } res_t;

endpackage

/* rtl/fpa_in_if.sv */
`timescale 1ns / 1ps
interface fpa_in_if import fpa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [3:0]               mode;
    logic signed [WORD_W-1:0] operand_a;
    logic signed [WORD_W-1:0] operand_b;

    modport source (output valid, output mode, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input mode, input operand_a, input operand_b,
                  output ready);
endinterface

/* rtl/fpa_out_if.sv */
`timescale 1ns / 1ps
interface fpa_out_if import fpa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] result_word;
    logic                     compare_true;
    logic [1:0]               status;

    modport source (output valid, output result_word, output compare_true,
                    output status, input ready);
    modport sink (input valid, input result_word, input compare_true,
                  input status, output ready);
endinterface

/* rtl/fpa_front.sv */
`timescale 1ns / 1ps
module fpa_front import fpa_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_valid,
    input  logic [3:0]               mode,
    input  logic signed [WORD_W-1:0] operand_a,
    input  logic signed [WORD_W-1:0] operand_b,
    output carry_t                   carry_out,
    output div_t                     div_out
);

    side_t             side1_reg;
    side_t             side1_next;
    logic [WORD_W-1:0] mag_a_reg;
    logic [WORD_W-1:0] mag_a_next;
    logic [WORD_W-1:0] mag_b_reg;
    logic [WORD_W-1:0] mag_b_next;
    carry_t            carry_reg;
    carry_t            carry_next;
    div_t              div_reg;
    div_t              div_next;
    logic              lt;
    logic              gt;
    op_t               op;

    assign op = op_t'(mode);
    assign lt = operand_a < operand_b;
    assign gt = operand_b < operand_a;

    always_comb
    begin
        side1_next          = '0;
        side1_next.valid    = in_valid;
        side1_next.mode     = op;
        side1_next.neg      = operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
        side1_next.div_zero = (operand_b == '0);
        case (op)
            OP_ADD:      side1_next.simple_r = operand_a + operand_b;
            OP_SUB:      side1_next.simple_r = operand_a - operand_b;
            OP_GT:       side1_next.cmp = gt;
            OP_LT:       side1_next.cmp = lt;
            OP_GE:       side1_next.cmp = !lt;
            OP_LE:       side1_next.cmp = !gt;
            OP_EQ:       side1_next.cmp = (operand_a == operand_b);
            OP_NE:       side1_next.cmp = (operand_a != operand_b);
            OP_INC:      side1_next.simple_r = operand_a + WORD_W'(1);
            OP_DEC:      side1_next.simple_r = operand_a - WORD_W'(1);
            OP_MIN:      side1_next.simple_r = lt ? operand_a : operand_b;
            OP_MAX:      side1_next.simple_r = gt ? operand_a : operand_b;
            OP_FROM_INT: side1_next.simple_r = operand_a <<< FRAC_W;
            OP_TO_INT:   side1_next.simple_r = operand_a >>> FRAC_W;
            default:     side1_next.simple_r = '0;
        endcase
        mag_a_next = operand_a[WORD_W-1] ? WORD_W'(-operand_a) : WORD_W'(operand_a);
        mag_b_next = operand_b[WORD_W-1] ? WORD_W'(-operand_b) : WORD_W'(operand_b);
    end

    // Second stage: the multiplier and the divider's starting point.
    always_comb
    begin
        carry_next.side    = side1_reg;
        carry_next.prod    = mag_a_reg * mag_b_reg;
        div_next.rem       = '0;
        div_next.num       = DIV_NUM_W'({mag_a_reg, {FRAC_W{1'b0}}});
        div_next.quo       = '0;
        div_next.divisor   = mag_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            mag_a_reg <= '0;
            mag_b_reg <= '0;
            carry_reg <= '0;
            div_reg   <= '0;
        end
        else if (advance)
        begin
            side1_reg <= side1_next;
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
            carry_reg <= carry_next;
            div_reg   <= div_next;
        end
    end

    assign carry_out = carry_reg;
    assign div_out   = div_reg;

endmodule

/* rtl/fpa_div_stage.sv */
`timescale 1ns / 1ps
module fpa_div_stage import fpa_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  carry_t carry_in,
    input  div_t   div_in,
    output carry_t carry_out,
    output div_t   div_out
);

    carry_t carry_reg;
    div_t   div_reg;
    div_t   div_next;

    // Restoring division, a few quotient bits per stage, numerator MSB first.
    always_comb
    begin
        logic [WORD_W:0] trial;
        div_next = div_in;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial        = {div_next.rem, div_next.num[DIV_NUM_W-1]};
            div_next.num = {div_next.num[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, div_next.divisor})
            begin
                div_next.rem = WORD_W'(trial - {1'b0, div_next.divisor});
                div_next.quo = {div_next.quo[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                div_next.rem = trial[WORD_W-1:0];
                div_next.quo = {div_next.quo[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
            div_reg   <= '0;
        end
        else if (advance)
        begin
            carry_reg <= carry_in;
            div_reg   <= div_next;
        end
    end

    assign carry_out = carry_reg;
    assign div_out   = div_reg;

endmodule

/* rtl/fpa_finish.sv */
`timescale 1ns / 1ps
module fpa_finish import fpa_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  carry_t carry_in,
    input  div_t   div_in,
    output logic   out_valid,
    output res_t   res_out
);

    localparam logic [MAG_W-1:0]  MAG_MAX  = (MAG_W'(1) << (WORD_W - 1)) - MAG_W'(1);
    localparam logic [MAG_W-1:0]  MAG_MIN  = MAG_W'(1) << (WORD_W - 1);
    localparam logic [PROD_W:0]   HALF     = (PROD_W + 1)'(1) << (FRAC_W - 1);

    side_t             side_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [MAG_W-1:0]  mag_next;
    logic [PROD_W:0]   mul_sum;
    logic [DIV_MAG_W-1:0] div_mag;
    logic              div_up;
    logic              valid_reg;
    res_t              res_reg;
    res_t              res_next;
    logic              sat;
    logic [WORD_W-1:0] word;

    // Rounding, half away from zero on the magnitude.
    assign mul_sum = {1'b0, carry_in.prod} + HALF;
    assign div_up  = {div_in.rem, 1'b0} >= {1'b0, div_in.divisor};
    assign div_mag = {1'b0, div_in.quo} + DIV_MAG_W'(div_up);

    always_comb
    begin
        if (carry_in.side.mode == OP_MUL)
            mag_next = MAG_W'(mul_sum[PROD_W:FRAC_W]);
        else
            mag_next = MAG_W'(div_mag);
    end

    assign sat  = mag_reg > (side_reg.neg ? MAG_MIN : MAG_MAX);

    always_comb
    begin
        if (sat)
            word = side_reg.neg ? WORD_W'(MAG_MIN) : WORD_W'(MAG_MAX);
        else if (side_reg.neg)
            word = WORD_W'(-mag_reg[WORD_W-1:0]);
        else
            word = mag_reg[WORD_W-1:0];
    end

    always_comb
    begin
        res_next.result_word  = side_reg.simple_r;
        res_next.compare_true = side_reg.cmp;
        res_next.status       = ST_OK;
        if (side_reg.mode == OP_MUL)
        begin
            res_next.result_word = word;
            res_next.status      = sat ? ST_SAT : ST_OK;
        end
        else if (side_reg.mode == OP_DIV)
        begin
            if (side_reg.div_zero)
            begin
                res_next.result_word = '0;
                res_next.status      = ST_DIV0;
            end
            else
            begin
                res_next.result_word = word;
                res_next.status      = sat ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= '0;
            mag_reg   <= '0;
            valid_reg <= 1'b0;
            res_reg   <= '0;
        end
        else if (advance)
        begin
            side_reg  <= carry_in.side;
            mag_reg   <= mag_next;
            valid_reg <= side_reg.valid;
            res_reg   <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

/* rtl/fixed_point_alu.sv */
`timescale 1ns / 1ps
// Signed Q24.8 fixed-point ALU. Every item passes through the same 14-stage
// pipeline (two stages of operand preparation and multiply, ten stages of a
// restoring divider that resolves four quotient bits each, two stages of
// rounding and saturation), and one item is taken in every cycle while the
// pipeline is not stalled. When the result side stalls the whole pipeline
// holds, and in_ch.ready is low only while the output register holds a
// result that has not been taken.
module fixed_point_alu import fpa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    fpa_in_if.sink   in_ch,
    fpa_out_if.source out_ch
);

    logic   advance;
    logic   out_valid;
    res_t   res;
    carry_t carry [DIV_STAGES+1];
    div_t   divs  [DIV_STAGES+1];

    assign advance     = !out_valid || out_ch.ready;
    assign in_ch.ready = advance;

    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_ch.valid),
        .mode      (in_ch.mode),
        .operand_a (in_ch.operand_a),
        .operand_b (in_ch.operand_b),
        .carry_out (carry[0]),
        .div_out   (divs[0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        fpa_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .carry_in  (carry[s]),
            .div_in    (divs[s]),
            .carry_out (carry[s+1]),
            .div_out   (divs[s+1])
        );
    end

    fpa_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .carry_in  (carry[DIV_STAGES]),
        .div_in    (divs[DIV_STAGES]),
        .out_valid (out_valid),
        .res_out   (res)
    );

    assign out_ch.valid        = out_valid;
    assign out_ch.result_word  = res.result_word;
    assign out_ch.compare_true = res.compare_true;
    assign out_ch.status       = res.status;

endmodule

/* test/fixed_point_alu_checker.sv */
`timescale 1ns / 1ps
module fixed_point_alu_checker import fpa_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    fpa_in_if.sink    in_mon,
    fpa_out_if.sink   out_mon,
    output int        mismatch_count,
    output int        pending_count,
    output int        result_count
);

    res_t alu_results_q[$];

    // Saturates a signed magnitude result to the 32-bit word range.
    function automatic logic [31:0] clamp_word(input logic [127:0] mag, input logic neg,
                                               inout logic sat);
        logic [127:0] lim;
        begin
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (mag > lim)
            begin
                sat = 1'b1;
                return neg ? 32'h8000_0000 : 32'h7fff_ffff;
            end
            return neg ? (32'd0 - mag[31:0]) : mag[31:0];
        end
    endfunction

    function automatic res_t compute_alu(input logic [3:0] mode, input logic signed [31:0] a,
                                         input logic signed [31:0] b);
        res_t r;
        logic [127:0] ma, mb, p, q, rm;
        logic neg, sat;
        begin
            r = '0;
            sat = 1'b0;
            neg = a[31] ^ b[31];
            ma = a[31] ? 128'(-64'(a)) : 128'(a);
            mb = b[31] ? 128'(-64'(b)) : 128'(b);
            case (op_t'(mode))
                OP_ADD: r.result_word = a + b;
                OP_SUB: r.result_word = a - b;
                OP_MUL:
                begin
                    p = (ma * mb + 128'd128) >> FRAC_W;
                    r.result_word = clamp_word(p, neg, sat);
                end
                OP_DIV:
                begin
                    if (b == 0)
                        r.status = ST_DIV0;
                    else
                    begin
                        q = (ma << FRAC_W) / mb;
                        rm = (ma << FRAC_W) % mb;
                        if (rm >= mb - rm)
                            q = q + 1;
                        r.result_word = clamp_word(q, neg, sat);
                    end
                end
                OP_GT: r.compare_true = a > b;
                OP_LT: r.compare_true = a < b;
                OP_GE: r.compare_true = a >= b;
                OP_LE: r.compare_true = a <= b;
                OP_EQ: r.compare_true = a == b;
                OP_NE: r.compare_true = a != b;
                OP_INC: r.result_word = a + 1;
                OP_DEC: r.result_word = a - 1;
                OP_MIN: r.result_word = (a < b) ? a : b;
                OP_MAX: r.result_word = (a > b) ? a : b;
                OP_FROM_INT: r.result_word = a <<< FRAC_W;
                default: r.result_word = a >>> FRAC_W;
            endcase
            if (sat)
                r.status = ST_SAT;
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            mismatch_count <= 0;
            result_count <= 0;
            pending_count <= 0;
            alu_results_q.delete();
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
                alu_results_q.push_back(compute_alu(in_mon.mode, in_mon.operand_a,
                                                    in_mon.operand_b));
            if (out_mon.valid && out_mon.ready)
            begin
                result_count <= result_count + 1;
                if (alu_results_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result item %h", out_mon.result_word);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = alu_results_q.pop_front();
                    if (want.result_word !== out_mon.result_word ||
                        want.compare_true !== out_mon.compare_true ||
                        want.status !== out_mon.status)
                    begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected %h/%b/%0d, got %h/%b/%0d",
                                     want.result_word, want.compare_true, want.status,
                                     out_mon.result_word, out_mon.compare_true,
                                     out_mon.status);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            pending_count <= alu_results_q.size();
        end
    end

endmodule

/* test/fixed_point_alu_tb.sv */
`timescale 1ns / 1ps
module fixed_point_alu_tb;
    import fpa_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   mismatch_count, pending_count, result_count;
    int   cycle_count = 0;
    logic hold_off = 1'b0;

    fpa_in_if  in_ch();
    fpa_out_if out_ch();

    fixed_point_alu dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    fixed_point_alu_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
        .mismatch_count(mismatch_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready = 1'b0;
    end

    function automatic int gap_len();
        int p;
        begin
            p = $urandom_range(0, 99);
            if (p < 55)
                return 0;
            if (p < 93)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    function automatic logic [31:0] pick_operand();
        begin
            case ($urandom_range(0, 7))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'(int'($urandom_range(0, 1024)) - 512);
                3: return 32'(int'($urandom_range(0, 131072)) - 65536);
                4: return 32'h0;
                default: return $urandom();
            endcase
        end
    endfunction

    task automatic send_item(input logic [3:0] mode, input logic [31:0] a,
                             input logic [31:0] b);
        begin
            in_ch.valid <= 1'b1;
            in_ch.mode <= mode;
            in_ch.operand_a <= a;
            in_ch.operand_b <= b;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
        end
    endtask

    task automatic idle_sender(input int n);
        begin
            if (n > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    endtask

    // Receiver: random gaps, plus one long hold counted here once hold_off is raised.
    initial
    begin
        int n;
        logic held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && !held)
            begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
            begin
                n = gap_len();
                if (n > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] edge_vals[6];
        int k;
        edge_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h100, 32'hffff_ff00, 32'h80};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int op = 0; op < 16; op++)
            send_item(op[3:0], edge_vals[op % 6], edge_vals[(op + 1) % 6]);
        send_item(OP_DIV, 32'h100, 32'h0);
        send_item(OP_DIV, 32'h7fff_ffff, 32'h1);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_MUL, 32'hffff_ff80, 32'h1);
        send_item(OP_EQ, 32'h55, 32'h55);
        send_item(OP_INC, 32'h7fff_ffff, 32'h0);
        send_item(OP_DEC, 32'h8000_0000, 32'h0);
        send_item(OP_TO_INT, 32'hffff_ff01, 32'h0);
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 600)
                hold_off <= 1'b1;
            send_item(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
            idle_sender(gap_len());
        end
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        $display("ran %0d results over all 16 operations with edge operands,", result_count);
        $display("random stalls on both sides and one long receiver hold.");
        if (mismatch_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fpa_pkg.sv
rtl/fpa_in_if.sv
rtl/fpa_out_if.sv
rtl/fpa_front.sv
rtl/fpa_div_stage.sv
rtl/fpa_finish.sv
rtl/fixed_point_alu.sv
test/fixed_point_alu_checker.sv
test/fixed_point_alu_tb.sv
